// ----- hw/rtl/lrs_pkg.sv -----
// Shared constants, types and controller interface structs for the radix sort unit.
package lrs_pkg;

    localparam int MAX_ROWS    = 4096;
    localparam int AW          = $clog2(MAX_ROWS);
    localparam int CW          = $clog2(MAX_ROWS + 1);
    localparam int KEY_W       = 64;
    localparam int IDX_W       = 12;
    localparam int BIN_W       = 8;
    localparam int BINS        = 256;
    localparam int NUM_PASSES  = 8;
    localparam int PASS_W      = 3;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [4:0] {
        ST_CLR_RST,
        ST_LOAD,
        ST_LD_DISP,
        ST_OUT,
        ST_OUT_DISP,
        ST_LD_A,
        ST_LD_B,
        ST_PASS_INIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_SCAN_DEC,
        ST_SCT_A,
        ST_SCT_B,
        ST_SCT_C,
        ST_PASS_NEXT,
        ST_CLR_SORT,
        ST_RD_A,
        ST_RD_B
    } t_state;

    typedef struct packed {
        logic capture;
        logic new_seq;
        logic ld_rd;
        logic ld_wr;
        logic clr;
        logic bin_inc;
        logic scan_rd;
        logic pass_init;
        logic pass_adv;
        logic src_elem;
        logic sc_mv;
        logic sc_wr;
        logic flip;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  in_op;
        logic in_last;
        logic multi;
        logic bin_last;
        logic pass_last;
        logic elem_last;
        logic rd_ok;
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/lrs_ctrl.sv -----
// Controller state machine sequencing load, histogram scan, scatter, clear and read-out.
module lrs_ctrl import lrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR_RST;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            ST_CLR_RST: begin
                o_cmd.clr     = 1'b1;
                o_cmd.bin_inc = 1'b1;
                if (i_sts.bin_last) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LD_DISP;
                end
            end
            ST_LD_DISP: begin
                // A read while loading is dropped.
                n_state = (i_sts.in_op == OP_LOAD) ? ST_LD_A : ST_LOAD;
            end
            ST_OUT: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_OUT_DISP;
                end
            end
            ST_OUT_DISP: begin
                if (i_sts.in_op == OP_LOAD) begin
                    o_cmd.new_seq = 1'b1;
                    n_state       = ST_LD_A;
                end else if (i_sts.rd_ok) begin
                    n_state = ST_RD_A;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_LD_A: begin
                o_cmd.ld_rd = 1'b1;
                n_state     = ST_LD_B;
            end
            ST_LD_B: begin
                o_cmd.ld_wr = 1'b1;
                n_state     = i_sts.in_last ? ST_PASS_INIT : ST_LOAD;
            end
            ST_PASS_INIT: begin
                o_cmd.pass_init = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                o_cmd.bin_inc = 1'b1;
                if (i_sts.bin_last) n_state = ST_SCAN_END;
            end
            ST_SCAN_END: begin
                n_state = ST_SCAN_DEC;
            end
            ST_SCAN_DEC: begin
                n_state = i_sts.multi ? ST_SCT_A : ST_PASS_NEXT;
            end
            ST_SCT_A: begin
                o_cmd.src_elem = 1'b1;
                n_state        = ST_SCT_B;
            end
            ST_SCT_B: begin
                o_cmd.src_elem = 1'b1;
                o_cmd.sc_mv    = 1'b1;
                n_state        = ST_SCT_C;
            end
            ST_SCT_C: begin
                o_cmd.sc_wr = 1'b1;
                if (i_sts.elem_last) begin
                    o_cmd.flip = 1'b1;
                    n_state    = ST_PASS_NEXT;
                end else begin
                    n_state = ST_SCT_A;
                end
            end
            ST_PASS_NEXT: begin
                o_cmd.pass_adv = 1'b1;
                n_state        = i_sts.pass_last ? ST_CLR_SORT : ST_PASS_INIT;
            end
            ST_CLR_SORT: begin
                o_cmd.clr     = 1'b1;
                o_cmd.bin_inc = 1'b1;
                if (i_sts.bin_last) n_state = ST_OUT;
            end
            ST_RD_A: begin
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_OUT;
                end
            end
            default: begin
                n_state = ST_CLR_RST;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lrs_dp.sv -----
// Datapath: ping-pong stores, byte histograms, bucket offsets, counters and output register.
module lrs_dp import lrs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_in_op,
    input  logic [KEY_W-1:0]       i_in_key,
    input  logic [IDX_W-1:0]       i_in_idx,
    input  logic                   i_in_last,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [KEY_W-1:0]       o_out_key,
    output logic [IDX_W-1:0]       o_out_idx,
    output logic                   o_out_last
);

    // Captured request.
    t_op                r_in_op;
    logic [KEY_W-1:0]   r_in_key;
    logic [IDX_W-1:0]   r_in_idx;
    logic               r_in_last;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_rp;
    logic               r_live;
    logic [PASS_W-1:0]  r_pass;
    logic [BIN_W-1:0]   r_bin;
    logic [BIN_W-1:0]   r_bin_d;
    logic               r_scan_v;
    logic [CW-1:0]      r_total;
    logic [1:0]         r_occ;
    logic [AW-1:0]      r_elem;

    logic [KEY_W-1:0]   r_mv_key;
    logic [IDX_W-1:0]   r_mv_idx;
    logic [BIN_W-1:0]   r_mv_bin;

    logic               r_out_valid;
    logic [KEY_W-1:0]   r_out_key;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_last;

    logic               full;
    logic               ld_we;
    logic [KEY_W-1:0]   rd_key;
    logic [IDX_W-1:0]   rd_idx;
    logic [BIN_W-1:0]   src_bin;
    logic [CW-1:0]      h_sel;
    logic [CW-1:0]      off_rdata;
    logic [CW-1:0]      h_rdata [NUM_PASSES];

    assign full  = (r_count == CW'(MAX_ROWS));
    assign ld_we = i_cmd.ld_wr && !full;

    // ---------------- element stores ----------------
    logic [KEY_W-1:0] key_a [MAX_ROWS];
    logic [KEY_W-1:0] key_b [MAX_ROWS];
    logic [IDX_W-1:0] idx_a [MAX_ROWS];
    logic [IDX_W-1:0] idx_b [MAX_ROWS];
    logic [KEY_W-1:0] ka_rd, kb_rd;
    logic [IDX_W-1:0] ia_rd, ib_rd;
    logic [AW-1:0]    st_raddr;
    logic [AW-1:0]    st_waddr;
    logic [KEY_W-1:0] st_wkey;
    logic [IDX_W-1:0] st_widx;
    logic             we_a, we_b;

    assign st_raddr = i_cmd.src_elem ? r_elem : r_rp[AW-1:0];
    assign st_waddr = ld_we ? r_count[AW-1:0] : off_rdata[AW-1:0];
    assign st_wkey  = ld_we ? r_in_key : r_mv_key;
    assign st_widx  = ld_we ? r_in_idx : r_mv_idx;
    // Loads go to the live store, scatter goes to the other one.
    assign we_a = (ld_we && !r_live) || (i_cmd.sc_wr && r_live);
    assign we_b = (ld_we && r_live) || (i_cmd.sc_wr && !r_live);

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            key_a[st_waddr] <= st_wkey;
            idx_a[st_waddr] <= st_widx;
        end
        ka_rd <= key_a[st_raddr];
        ia_rd <= idx_a[st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            key_b[st_waddr] <= st_wkey;
            idx_b[st_waddr] <= st_widx;
        end
        kb_rd <= key_b[st_raddr];
        ib_rd <= idx_b[st_raddr];
    end

    assign rd_key  = r_live ? kb_rd : ka_rd;
    assign rd_idx  = r_live ? ib_rd : ia_rd;
    assign src_bin = rd_key[{r_pass, 3'b000} +: BIN_W];

    // ---------------- byte histograms, one bank per key byte ----------------
    for (genvar g = 0; g < NUM_PASSES; g++) begin : g_hist
        logic [CW-1:0]    hmem [BINS];
        logic [BIN_W-1:0] h_raddr;
        logic [BIN_W-1:0] h_waddr;
        logic [CW-1:0]    h_wdata;
        logic             h_we;

        assign h_raddr = i_cmd.ld_rd ? r_in_key[g*BIN_W +: BIN_W] : r_bin;
        assign h_we    = ld_we || i_cmd.clr;
        assign h_waddr = ld_we ? r_in_key[g*BIN_W +: BIN_W] : r_bin;
        assign h_wdata = ld_we ? h_rdata[g] + CW'(1) : '0;

        always_ff @(posedge i_clk) begin
            if (h_we) hmem[h_waddr] <= h_wdata;
            h_rdata[g] <= hmem[h_raddr];
        end
    end

    assign h_sel = h_rdata[r_pass];

    // ---------------- bucket offsets ----------------
    logic [CW-1:0]    omem [BINS];
    logic [BIN_W-1:0] o_waddr;
    logic [CW-1:0]    o_wdata;

    assign o_waddr = r_scan_v ? r_bin_d : r_mv_bin;
    assign o_wdata = r_scan_v ? r_total : off_rdata + CW'(1);

    always_ff @(posedge i_clk) begin
        if (r_scan_v || i_cmd.sc_wr) omem[o_waddr] <= o_wdata;
        off_rdata <= omem[src_bin];
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_op   <= t_op'(i_in_op);
            r_in_key  <= i_in_key;
            r_in_idx  <= i_in_idx;
            r_in_last <= i_in_last;
        end
        if (i_cmd.sc_mv) begin
            r_mv_key <= rd_key;
            r_mv_idx <= rd_idx;
            r_mv_bin <= src_bin;
        end
        if (i_cmd.out_load) begin
            r_out_key  <= rd_key;
            r_out_idx  <= rd_idx;
            r_out_last <= (r_rp + CW'(1) == r_count);
        end
        r_bin_d <= r_bin;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rp        <= '0;
            r_live      <= 1'b0;
            r_pass      <= '0;
            r_bin       <= '0;
            r_scan_v    <= 1'b0;
            r_total     <= '0;
            r_occ       <= '0;
            r_elem      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_scan_v <= i_cmd.scan_rd;
            if (i_cmd.new_seq) begin
                r_count <= '0;
                r_rp    <= '0;
                r_live  <= 1'b0;
            end
            if (ld_we) r_count <= r_count + CW'(1);
            if (i_cmd.bin_inc) r_bin <= r_bin + BIN_W'(1);
            if (i_cmd.pass_init) begin
                r_total <= '0;
                r_occ   <= '0;
                r_elem  <= '0;
            end
            // Accumulate the exclusive prefix and count occupied bins, saturating at two.
            if (r_scan_v) begin
                r_total <= r_total + h_sel;
                if (h_sel != '0 && !r_occ[1]) r_occ <= r_occ + 2'd1;
            end
            if (i_cmd.sc_wr) r_elem <= r_elem + AW'(1);
            if (i_cmd.flip) r_live <= ~r_live;
            if (i_cmd.pass_adv) r_pass <= r_pass + PASS_W'(1);
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_rp        <= r_rp + CW'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.in_op     = r_in_op;
    assign o_sts.in_last   = r_in_last;
    assign o_sts.multi     = r_occ[1];
    assign o_sts.bin_last  = (r_bin == BIN_W'(BINS - 1));
    assign o_sts.pass_last = (r_pass == PASS_W'(NUM_PASSES - 1));
    assign o_sts.elem_last = ({1'b0, r_elem} + CW'(1) == r_count);
    assign o_sts.rd_ok     = (r_rp < r_count);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_key   = r_out_key;
    assign o_out_idx   = r_out_idx;
    assign o_out_last  = r_out_last;

endmodule

// ----- hw/rtl/lsd_radix_sort_u64_with_index_unit.sv -----
// Top level of the stable LSD radix sort unit for 64-bit keys with 12-bit row indexes.
// Load request: dispatched, then one histogram read-modify-write before ready is raised again.
// Sort after the last load: 8 passes, each a histogram prefix scan over all 256 bins, plus
// a scatter of every element for each pass with more than one occupied bin, then a clear of all bins.
// Read request: the store is read, the result loads once the output register is free, then ready returns.
// Reset is synchronous and active low; all 256 histogram bins are then cleared before ready rises.
module lsd_radix_sort_u64_with_index_unit import lrs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata fields from bit 0: sort_key[63:0], payload_index[75:64], zero pad[79:76].
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser field: opcode (0 = load, 1 = read next sorted element).
    input  logic                   s_axis_tuser,
    // tlast carries load_last.
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata fields from bit 0: sorted_index[11:0], sorted_key[75:12], zero pad[79:76].
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tlast carries out_last, set on the final sorted element.
    output logic                   m_axis_tlast
);

    t_cmd             cmd;
    t_sts             sts;
    logic [KEY_W-1:0] out_key;
    logic [IDX_W-1:0] out_idx;

    // The controller owns the request handshake; everything it moves lives in the datapath.
    lrs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // The datapath holds both element stores, the eight byte histograms, the offset table
    // and the output register, so a finished result can wait while the next request enters.
    lrs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_op     (s_axis_tuser),
        .i_in_key    (s_axis_tdata[KEY_W-1:0]),
        .i_in_idx    (s_axis_tdata[KEY_W +: IDX_W]),
        .i_in_last   (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_key   (out_key),
        .o_out_idx   (out_idx),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - KEY_W - IDX_W)'(0), out_key, out_idx};

endmodule

// ----- hw/rtl/lrs_checker.sv -----
// Port-level assertions for the radix sort unit and their bind to the top level.
module lrs_checker import lrs_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   s_axis_tuser,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // A new result only appears after a read request was being worked on.
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

    // An accepted request is worked on before another is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken back to back");

    // The histogram clear after reset holds off requests.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during reset clear");

endmodule

bind lsd_radix_sort_u64_with_index_unit lrs_checker u_lrs_checker (.*);
